FILE: rtl/trial_division_factorizer_top_assert.svh
// Assertion macros for the factorizer.
`ifndef TRIAL_DIVISION_FACTORIZER_TOP_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TDF_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TDF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TDF_ASSERT_IMPL(label, clk, rst, prop, msg)
`define TDF_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/tdf_pkg.sv
package tdf_pkg;
   localparam int VALUE_BITS_DEF = 32;
   localparam int FACTOR_W = 32;
   localparam int EXP_W = 5;
   localparam int MAX_RESULTS = 10;
   localparam int CNT_W = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DIV_DONE,
      ST_EMIT,
      ST_TAIL,
      ST_WAIT_OUT
   } state_type;

   // divider handshake group
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage

FILE: rtl/tdf_divider.sv
// Restoring divider, one quotient bit per cycle.
module tdf_divider #(
   parameter int W = tdf_pkg::VALUE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [W-1:0]         dividend,
   input  logic [W-1:0]         divisor,
   output logic [W-1:0]         quotient,
   output logic [W-1:0]         remainder,
   output tdf_pkg::div_stat_type stat
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   // one shift-subtract step
   always_comb begin
      trial = {r_ff, q_ff[W-1]};
      diff = trial - {1'b0, d_ff};
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            r_in = diff[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign remainder = r_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

FILE: rtl/trial_division_factorizer_top.sv
// Channel | Dir | Ports                                  | Beat when
// req     | in  | req_valid, req_stall, req_value        | req_valid && !req_stall
// rsp     | out | rsp_valid, rsp_stall, rsp_factor/...  | rsp_valid && !rsp_stall
// One item at a time; req_stall is high from acceptance until its run is delivered.
// Each trial division runs on the bit-serial divider; every candidate d costs one division,
// and each time d divides out costs one more. The quotient also gives the d <= m/d test,
// so an item takes about sqrt(|value|) divisions, plus one per factor.
// Reset is synchronous; it clears the sequencer and output valid.
// A stalled result holds the sequencer; nothing is lost.
`include "trial_division_factorizer_top_assert.svh"
module trial_division_factorizer_top #(
   parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [31:0]           rsp_factor,
   output logic [tdf_pkg::EXP_W-1:0]    rsp_exponent,
   output logic                         rsp_last
);
   localparam int W = VALUE_BITS;
   localparam int FW = tdf_pkg::FACTOR_W;
   localparam int EW = tdf_pkg::EXP_W;
   localparam int CNTW = tdf_pkg::CNT_W;

   tdf_pkg::state_type state_ff, state_in;

   logic [W-1:0]    m_ff, m_in;
   logic [W-1:0]    d_ff, d_in;
   logic [EW-1:0]   e_ff, e_in;
   logic            dfound_ff, dfound_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            rv_ff, rv_in;
   logic [FW-1:0]   rf_ff, rf_in;
   logic [EW-1:0]   re_ff, re_in;
   logic            rl_ff, rl_in;
   logic [FW-1:0]   pf_ff, pf_in;
   logic [EW-1:0]   pe_ff, pe_in;
   logic            pv_ff, pv_in;
   logic            endrun_ff, endrun_in;
   logic [W-1:0]    vin, mag;
   logic            div_start;
   logic [W-1:0]    quo, rem;
   logic            in_idle;
   tdf_pkg::div_stat_type dstat;

   tdf_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(m_ff), .divisor(d_ff),
      .quotient(quo), .remainder(rem), .stat(dstat)
   );

   // input taken to VALUE_BITS, sign-extended
   always_comb begin
      vin = W'($signed(req_value));
      mag = vin[W-1] ? (~vin + 1'b1) : vin;
   end

   assign in_idle = (state_ff == tdf_pkg::ST_IDLE);

   // a result is pending (pv) until it moves to the output register
   logic out_free;
   logic push;
   assign out_free = !rv_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdf_pkg::ST_IDLE: if (req_valid && vin != '0) state_in = tdf_pkg::ST_CHECK;
         tdf_pkg::ST_CHECK: if (!pv_ff) state_in = (m_ff == W'(1)) ? tdf_pkg::ST_TAIL
                                                                   : tdf_pkg::ST_DIV_START;
         tdf_pkg::ST_DIV_START: state_in = tdf_pkg::ST_DIV_WAIT;
         tdf_pkg::ST_DIV_WAIT: if (dstat.done) state_in = tdf_pkg::ST_DIV_DONE;
         tdf_pkg::ST_DIV_DONE: begin
            // a fresh candidate above m/d ends the search
            if (!dfound_ff && quo < d_ff) state_in = tdf_pkg::ST_TAIL;
            else if (rem == '0) state_in = tdf_pkg::ST_DIV_START;
            else if (dfound_ff) state_in = tdf_pkg::ST_EMIT;
            else state_in = tdf_pkg::ST_DIV_START;
         end
         tdf_pkg::ST_EMIT: if (!pv_ff) state_in = tdf_pkg::ST_DIV_START;
         tdf_pkg::ST_TAIL: if (!pv_ff) state_in = tdf_pkg::ST_WAIT_OUT;
         tdf_pkg::ST_WAIT_OUT: if (!pv_ff && !rv_ff) state_in = tdf_pkg::ST_IDLE;
         default: state_in = tdf_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      m_in = m_ff; d_in = d_ff; e_in = e_ff; dfound_in = dfound_ff;
      cnt_in = cnt_ff;
      pf_in = pf_ff; pe_in = pe_ff; pv_in = pv_ff; endrun_in = endrun_ff;
      rv_in = rv_ff; rf_in = rf_ff; re_in = re_ff; rl_in = rl_ff;
      div_start = 1'b0;
      push = 1'b0;
      req_stall = !in_idle;

      // output register: drain, then load pending result
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (pv_ff && out_free) begin
         rv_in = 1'b1; rf_in = pf_ff; re_in = pe_ff; rl_in = endrun_ff;
         pv_in = 1'b0;
      end

      case (state_ff)
         tdf_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && vin != '0) begin
               m_in = mag; d_in = W'(2); e_in = '0; dfound_in = 1'b0;
               if (vin[W-1]) begin
                  pf_in = '1; pe_in = EW'(1); pv_in = 1'b1; endrun_in = 1'b0;
                  cnt_in = CNTW'(1);
               end
            end
         end
         tdf_pkg::ST_DIV_START: div_start = 1'b1;
         tdf_pkg::ST_DIV_DONE: begin
            if (!dfound_ff && quo < d_ff) begin
               // search over, m is left for the tail
            end else if (rem == '0) begin
               m_in = quo; e_in = e_ff + 1'b1; dfound_in = 1'b1;
            end else if (!dfound_ff) begin
               d_in = d_ff + 1'b1;
            end
         end
         tdf_pkg::ST_EMIT: if (!pv_ff) push = 1'b1;
         tdf_pkg::ST_TAIL: if (!pv_ff) push = 1'b1;
         default: ;
      endcase

      // queue a result; run limit caps the count
      if (push) begin
         if (state_ff == tdf_pkg::ST_EMIT) begin
            d_in = d_ff + 1'b1; e_in = '0; dfound_in = 1'b0;
            if (cnt_ff < CNTW'(tdf_pkg::MAX_RESULTS)) begin
               pf_in = FW'(d_ff); pe_in = e_ff; pv_in = 1'b1; cnt_in = cnt_ff + 1'b1;
               // nothing follows once m is fully divided out
               endrun_in = (cnt_ff == CNTW'(tdf_pkg::MAX_RESULTS - 1)) || (m_ff == W'(1));
            end
         end else begin
            if (cnt_ff < CNTW'(tdf_pkg::MAX_RESULTS) && m_ff > W'(1)) begin
               pf_in = FW'(m_ff); pe_in = EW'(1); pv_in = 1'b1; endrun_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (cnt_ff < CNTW'(tdf_pkg::MAX_RESULTS) && m_ff == W'(1)
                         && d_ff == W'(2)) begin
               // unit input
               pf_in = FW'(1); pe_in = EW'(1); pv_in = 1'b1; endrun_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; d_ff <= d_in; e_ff <= e_in; dfound_ff <= dfound_in;
      cnt_ff <= cnt_in;
      pf_ff <= pf_in; pe_ff <= pe_in; endrun_ff <= endrun_in;
      rf_ff <= rf_in; re_ff <= re_in; rl_ff <= rl_in;
      if (reset) begin
         state_ff <= tdf_pkg::ST_IDLE; rv_ff <= 1'b0; pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; pv_ff <= pv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_factor = rf_ff;
   assign rsp_exponent = re_ff;
   assign rsp_last = rl_ff;

   `TDF_ASSERT_NEVER(a_zero_exp, clock, reset, rsp_valid && rsp_exponent == '0, "zero exponent")
   `TDF_ASSERT_IMPL(a_idle_empty, clock, reset, in_idle |-> !pv_ff, "pending in idle")
   `TDF_ASSERT_NEVER(a_start_busy, clock, reset, div_start && dstat.busy, "divider restarted")
endmodule

FILE: dv/trial_division_factorizer_checker.sv
module trial_division_factorizer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [31:0]            req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [31:0]            rsp_factor,
   input  logic [tdf_pkg::EXP_W-1:0]     rsp_exponent,
   input  logic                          rsp_last,
   output int                            mismatches,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0]          factor;
      logic [tdf_pkg::EXP_W-1:0]   exponent;
      logic                        last;
   } prime_power_type;

   prime_power_type factor_queue[$];

   // push the factorization of one input value, trial division style
   function automatic void factorize(input logic signed [31:0] value);
      longint mag;
      longint d;
      int e;
      int first;
      prime_power_type pp;
      first = factor_queue.size();
      if (value == 0) return;
      mag = value;
      if (value < 0) begin
         mag = -mag;
         pp.factor = -32'sd1; pp.exponent = 1; pp.last = 1'b0;
         factor_queue.push_back(pp);
      end
      if (mag == 1) begin
         pp.factor = 32'sd1; pp.exponent = 1; pp.last = 1'b0;
         factor_queue.push_back(pp);
      end else begin
         d = 2;
         while (d <= mag / d) begin
            if (mag % d == 0) begin
               e = 0;
               while (mag % d == 0) begin
                  mag = mag / d;
                  e++;
               end
               pp.factor = d[31:0]; pp.exponent = e[4:0]; pp.last = 1'b0;
               factor_queue.push_back(pp);
            end
            d++;
         end
         if (mag > 1) begin
            pp.factor = mag[31:0]; pp.exponent = 1; pp.last = 1'b0;
            factor_queue.push_back(pp);
         end
      end
      if (factor_queue.size() > first)
         factor_queue[factor_queue.size()-1].last = 1'b1;
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      prime_power_type want;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req_valid && !req_stall) factorize(req_value);
         if (rsp_valid && !rsp_stall) begin
            if (factor_queue.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected beat: factor %0d exp %0d last %0d",
                           rsp_factor, rsp_exponent, rsp_last);
               mismatches <= mismatches + 1;
            end else begin
               want = factor_queue.pop_front();
               if (want.factor !== rsp_factor || want.exponent !== rsp_exponent ||
                   want.last !== rsp_last) begin
                  if (mismatches < 10)
                     $display("mismatch: exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                              want.factor, want.exponent, want.last,
                              rsp_factor, rsp_exponent, rsp_last);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      pending = factor_queue.size();
   end
endmodule

FILE: dv/trial_division_factorizer_top_test.sv
module trial_division_factorizer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 8000000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [31:0]          req_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [31:0]          rsp_factor;
   logic [tdf_pkg::EXP_W-1:0]   rsp_exponent;
   logic                        rsp_last;
   int                          mismatches;
   int                          pending;
   longint                      cycles = 0;

   int small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                          53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

   trial_division_factorizer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_factor(rsp_factor),
      .rsp_exponent(rsp_exponent), .rsp_last(rsp_last)
   );

   trial_division_factorizer_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_factor(rsp_factor),
      .rsp_exponent(rsp_exponent), .rsp_last(rsp_last),
      .mismatches(mismatches), .pending(pending)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall pattern: modes change every so often
   initial begin
      int mode;
      int left;
      rsp_stall = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(5, 60);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // cheap to factor: product of small primes, sign random
   function automatic logic signed [31:0] smooth_value();
      longint v;
      int p;
      v = 1;
      repeat ($urandom_range(1, 12)) begin
         p = small_primes[$urandom_range(0, small_primes.size() - 1)];
         if (v * p <= 64'sd2147483647) v = v * p;
      end
      if ($urandom_range(0, 1)) v = -v;
      return v[31:0];
   endfunction

   // one beat on the request channel, held while req_stall is high
   task automatic send_value(input logic signed [31:0] value);
      req_value <= value;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   int burst;

   initial begin
      logic signed [31:0] directed[$];
      logic signed [31:0] v;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: units, zero, powers, primes, near-extreme smooth values
      directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd4, 32'sd1073741824,
                   -32'sd1073741824, 32'sd2147483646, -32'sd2147483646, 32'sd65521,
                   -32'sd1000003, 32'sd223092870, -32'sd223092870, 32'sd1162261467,
                   32'sd2147483647, 32'sd97, 32'sd9409, 32'sd12, -32'sd360,
                   32'sd1610612736, -32'sd1207959552};
      foreach (directed[i]) begin
         send_value(directed[i]);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end

      // random part in bursts
      n = 0;
      while (n < 80) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            if ($urandom_range(0, 9) < 7) v = smooth_value();
            else begin
               v = $urandom_range(0, 65535);
               if ($urandom_range(0, 1)) v = -v;
            end
            send_value(v);
            n++;
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 20)) @(negedge clock);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
